// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the peak picker RTL. A module that
// uses them must have i_clk and i_rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while the block is out of reset.
`define ACPP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ACPP_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/acpp_pkg.sv =====
// ---------------------------------------------------------------------------
// acpp_pkg
// Types and constants shared by the autocorrelation peak picker modules.
// ---------------------------------------------------------------------------
package acpp_pkg;

    // Field widths.
    localparam int VALUE_W  = 16;   // Q1.15 autocorrelation sample
    localparam int LAG_W    = 12;   // lag bounds and peak index
    localparam int LEN_W    = 13;   // sequence length register
    localparam int OFFSET_W = 16;   // Q.15 sub-sample offset

    // Defaults and limits.
    localparam int DEF_MAX_LEN = 4096;
    localparam int MIN_LEN     = 3;
    localparam logic [LAG_W-1:0] RST_MIN_LAG = LAG_W'(1);
    localparam logic [LAG_W-1:0] RST_MAX_LAG = LAG_W'(4095);
    localparam logic [LEN_W-1:0] RST_SEQ_LEN = LEN_W'(4096);

    // Offset divider: quotient bits, and the Q15 value of one half sample.
    localparam int DIV_STEPS = OFFSET_W;
    localparam int HALF_Q15  = 16384;
    localparam int FRAC_SH   = 15;   // numerator is |r-l| * 2 * 16384

    // APB register map, byte addressed, one word per register.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_MIN_LAG = 2'd0,
        REG_MAX_LAG = 2'd1,
        REG_SEQ_LEN = 2'd2
    } t_reg_idx;

    typedef enum logic {
        ST_RUN = 1'b0,
        ST_DIV = 1'b1
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic sample_en;   // a sample transaction completes this cycle
        logic div_start;   // last sample: load the divider
        logic div_step;    // run one divider step
        logic out_load;    // capture the result into the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_last;     // the next sample closes the sequence
        logic div_done;    // all divider steps are done
    } t_sts;

endpackage

// ===== src/acpp_div.sv =====
// ---------------------------------------------------------------------------
// acpp_div
// Restoring divider for the parabolic offset, one quotient bit per step,
// with round-to-nearest, sign restore and clamping to one half sample.
// ---------------------------------------------------------------------------
module acpp_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_step,
    input  logic                                  i_found,
    input  logic        [acpp_pkg::LAG_W-1:0]     i_index,
    input  logic signed [acpp_pkg::VALUE_W-1:0]   i_value,
    input  logic signed [acpp_pkg::VALUE_W-1:0]   i_left,
    input  logic signed [acpp_pkg::VALUE_W-1:0]   i_right,
    output logic                                  o_done,
    output logic                                  o_found,
    output logic        [acpp_pkg::LAG_W-1:0]     o_index,
    output logic signed [acpp_pkg::OFFSET_W-1:0]  o_offset,
    output logic signed [acpp_pkg::VALUE_W-1:0]   o_value
);

    localparam int VW   = acpp_pkg::VALUE_W;
    localparam int DW   = VW + 2;                         // 2c - l - r
    localparam int NumW = VW + acpp_pkg::FRAC_SH + 1;     // 2|n| + d
    localparam int QW   = acpp_pkg::DIV_STEPS;
    localparam int ShW  = DW + QW - 1;                    // divisor shifted up
    localparam int StW  = $clog2(acpp_pkg::DIV_STEPS + 1);

    logic signed [DW-1:0]   w_d;
    logic signed [VW:0]     w_diff;
    logic        [VW-1:0]   w_mag;
    logic        [NumW-1:0] w_num;
    logic        [ShW-1:0]  w_dsh_init;
    logic                   w_ge;
    logic        [QW-1:0]   w_qc;

    logic        [NumW-1:0] r_rem;
    logic        [ShW-1:0]  r_dsh;
    logic        [QW-1:0]   r_q;
    logic        [StW-1:0]  r_step;
    logic                   r_neg;
    logic                   r_dpos;
    logic                   r_found;
    logic        [acpp_pkg::LAG_W-1:0]   r_index;
    logic signed [VW-1:0]   r_value;

    assign w_d    = (DW'(i_value) <<< 1) - DW'(i_left) - DW'(i_right);
    assign w_diff = (VW + 1)'(i_right) - (VW + 1)'(i_left);
    assign w_mag  = w_diff[VW] ? VW'(-w_diff) : VW'(w_diff);

    // Rounded quotient: (2|n| + d) / (2d), with |n| = |r-l| * 16384.
    assign w_num      = (NumW'(w_mag) << acpp_pkg::FRAC_SH) + NumW'($unsigned(w_d));
    assign w_dsh_init = ShW'($unsigned(w_d)) << QW;

    assign w_ge = ShW'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_start) begin
            r_step <= StW'(acpp_pkg::DIV_STEPS);
        end else if (i_step && (r_step != '0)) begin
            r_step <= r_step - StW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= w_num;
            r_dsh   <= w_dsh_init;
            r_q     <= '0;
            r_neg   <= w_diff[VW];
            r_dpos  <= !w_d[DW-1] && (w_d != '0);
            r_found <= i_found;
            r_index <= i_index;
            r_value <= i_value;
        end else if (i_step && (r_step != '0)) begin
            if (w_ge) begin
                r_rem <= r_rem - NumW'(r_dsh);
            end
            r_q   <= {r_q[QW-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign w_qc = (r_q > QW'(acpp_pkg::HALF_Q15)) ? QW'(acpp_pkg::HALF_Q15) : r_q;

    assign o_done   = (r_step == '0);
    assign o_found  = r_found;
    assign o_index  = r_found ? r_index : '0;
    assign o_value  = r_found ? r_value : '0;
    assign o_offset = (r_found && r_dpos) ? (r_neg ? -$signed(w_qc) : $signed(w_qc)) : '0;

endmodule

// ===== src/acpp_dp.sv =====
// ---------------------------------------------------------------------------
// acpp_dp
// Datapath: per-sample local maximum tracking, best peak registers, the
// offset divider and the result register.
// ---------------------------------------------------------------------------
module acpp_dp #(
    parameter int MAX_LEN = acpp_pkg::DEF_MAX_LEN
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  acpp_pkg::t_cmd                        i_cmd,
    output acpp_pkg::t_sts                        o_sts,
    input  logic        [acpp_pkg::LAG_W-1:0]     i_min_lag,
    input  logic        [acpp_pkg::LAG_W-1:0]     i_max_lag,
    input  logic        [acpp_pkg::LEN_W-1:0]     i_seq_len,
    input  logic signed [acpp_pkg::VALUE_W-1:0]   i_acf_value,
    output logic                                  o_found,
    output logic        [acpp_pkg::LAG_W-1:0]     o_peak_index,
    output logic signed [acpp_pkg::OFFSET_W-1:0]  o_peak_offset,
    output logic signed [acpp_pkg::VALUE_W-1:0]   o_peak_value
);

    localparam int VW   = acpp_pkg::VALUE_W;
    localparam int LW   = acpp_pkg::LEN_W;
    localparam int GW   = acpp_pkg::LAG_W;
    // Sample counter: the effective length never exceeds MAX_LEN or the
    // range of the length register.
    localparam int CntW = ($clog2(MAX_LEN) < LW) ? $clog2(MAX_LEN) : LW;

    logic        [CntW-1:0] r_cnt,      n_cnt;
    logic signed [VW-1:0]   r_prev,     n_prev;
    logic signed [VW-1:0]   r_pre,      n_pre;
    logic        [CntW-1:0] r_pstart,   n_pstart;
    logic signed [VW-1:0]   r_pval,     n_pval;
    logic                   r_in_pl,    n_in_pl;
    logic        [GW-1:0]   r_best_idx, n_best_idx;
    logic signed [VW-1:0]   r_best_val, n_best_val;
    logic signed [VW-1:0]   r_best_l,   n_best_l;
    logic signed [VW-1:0]   r_best_r,   n_best_r;

    logic        [LW-1:0]   w_len;
    logic        [CntW:0]   w_cnt_p1;
    logic                   w_is_last;
    logic                   w_div_done;
    logic        [CntW-1:0] w_right;
    logic        [CntW-1:0] w_mid;
    logic        [LW:0]     w_mid2;
    logic        [LW-1:0]   w_len_m1;
    logic                   w_fall;
    logic                   w_qual;
    logic                   w_upd;
    logic signed [VW-1:0]   w_l;
    logic signed [VW-1:0]   w_r;
    logic        [GW-1:0]   w_best_idx;
    logic signed [VW-1:0]   w_best_val;
    logic signed [VW-1:0]   w_best_l;
    logic signed [VW-1:0]   w_best_r;

    logic                   w_div_found;
    logic        [GW-1:0]   w_div_index;
    logic signed [acpp_pkg::OFFSET_W-1:0] w_div_offset;
    logic signed [VW-1:0]   w_div_value;

    // Effective length, clamped to the supported range.
    always_comb begin
        if (i_seq_len < LW'(acpp_pkg::MIN_LEN)) begin
            w_len = LW'(acpp_pkg::MIN_LEN);
        end else if (32'(i_seq_len) > 32'(MAX_LEN)) begin
            w_len = LW'(MAX_LEN);
        end else begin
            w_len = i_seq_len;
        end
    end

    assign w_cnt_p1  = {1'b0, r_cnt} + (CntW + 1)'(1);
    assign w_is_last = (LW + 1)'(w_cnt_p1) >= (LW + 1)'(w_len);

    always_comb begin
        o_sts          = '0;
        o_sts.is_last  = w_is_last;
        o_sts.div_done = w_div_done;
    end

    // Candidate peak: the middle of the flat top that ends at the previous
    // sample, left of centre for an even width.
    assign w_right  = r_cnt - CntW'(1);
    assign w_mid    = r_pstart + ((w_right - r_pstart) >> 1);
    assign w_mid2   = (LW + 1)'(w_mid) << 1;
    assign w_len_m1 = w_len - LW'(1);
    assign w_l      = (w_mid == r_pstart) ? r_pre : r_pval;
    assign w_r      = (w_mid == w_right) ? i_acf_value : r_pval;

    assign w_fall = (r_cnt != '0) && r_in_pl && (i_acf_value < r_pval);
    assign w_qual = (LW'(w_mid) >= LW'(i_min_lag)) && (LW'(w_mid) <= LW'(i_max_lag))
                  && (w_mid2 <= (LW + 1)'(w_len_m1))
                  && !r_pval[VW-1] && (r_pval != '0)
                  && ((r_best_idx == '0) || (r_pval > r_best_val));
    assign w_upd  = w_fall && w_qual;

    assign w_best_idx = w_upd ? GW'(w_mid) : r_best_idx;
    assign w_best_val = w_upd ? r_pval : r_best_val;
    assign w_best_l   = w_upd ? w_l : r_best_l;
    assign w_best_r   = w_upd ? w_r : r_best_r;

    always_comb begin
        n_cnt      = r_cnt;
        n_prev     = r_prev;
        n_pre      = r_pre;
        n_pstart   = r_pstart;
        n_pval     = r_pval;
        n_in_pl    = r_in_pl;
        n_best_idx = r_best_idx;
        n_best_val = r_best_val;
        n_best_l   = r_best_l;
        n_best_r   = r_best_r;
        if (i_cmd.sample_en) begin
            if (w_is_last) begin
                // The best peak has gone to the divider; start over.
                n_cnt      = '0;
                n_in_pl    = 1'b0;
                n_best_idx = '0;
            end else begin
                n_cnt      = CntW'(w_cnt_p1);
                n_prev     = i_acf_value;
                n_best_idx = w_best_idx;
                n_best_val = w_best_val;
                n_best_l   = w_best_l;
                n_best_r   = w_best_r;
                if (r_cnt != '0) begin
                    if (r_in_pl) begin
                        if (i_acf_value < r_pval) begin
                            n_in_pl = 1'b0;
                        end else if (i_acf_value > r_pval) begin
                            n_pre    = r_pval;
                            n_pstart = r_cnt;
                            n_pval   = i_acf_value;
                        end
                    end else if (i_acf_value > r_prev) begin
                        n_pre    = r_prev;
                        n_pstart = r_cnt;
                        n_pval   = i_acf_value;
                        n_in_pl  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_in_pl    <= 1'b0;
            r_best_idx <= '0;
        end else begin
            r_cnt      <= n_cnt;
            r_in_pl    <= n_in_pl;
            r_best_idx <= n_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev     <= n_prev;
        r_pre      <= n_pre;
        r_pstart   <= n_pstart;
        r_pval     <= n_pval;
        r_best_val <= n_best_val;
        r_best_l   <= n_best_l;
        r_best_r   <= n_best_r;
    end

    acpp_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_step   (i_cmd.div_step),
        .i_found  (w_best_idx != '0),
        .i_index  (w_best_idx),
        .i_value  (w_best_val),
        .i_left   (w_best_l),
        .i_right  (w_best_r),
        .o_done   (w_div_done),
        .o_found  (w_div_found),
        .o_index  (w_div_index),
        .o_offset (w_div_offset),
        .o_value  (w_div_value)
    );

    // Result register, so a waiting result holds up only the closing sample of the next sequence.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_found       <= w_div_found;
            o_peak_index  <= w_div_index;
            o_peak_offset <= w_div_offset;
            o_peak_value  <= w_div_value;
        end
    end

endmodule

// ===== src/acpp_ctrl.sv =====
// ---------------------------------------------------------------------------
// acpp_ctrl
// Controller: input and output handshakes, and sequencing of the offset
// divider at the end of each sequence.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module acpp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  acpp_pkg::t_sts  i_sts,
    output acpp_pkg::t_cmd  o_cmd
);

    acpp_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            acpp_pkg::ST_RUN: begin
                if (w_accept && i_sts.is_last) begin
                    n_state = acpp_pkg::ST_DIV;
                end
            end
            acpp_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = acpp_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = acpp_pkg::ST_RUN;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            acpp_pkg::ST_RUN: begin
                // The closing sample needs an empty result register.
                o_ready         = !(i_sts.is_last && r_out_valid);
                o_cmd.sample_en = i_valid && o_ready;
                o_cmd.div_start = i_valid && o_ready && i_sts.is_last;
            end
            acpp_pkg::ST_DIV: begin
                o_cmd.div_step = !i_sts.div_done;
                o_cmd.out_load = i_sts.div_done;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = o_cmd.sample_en;

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acpp_pkg::ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    `ACPP_ASSERT(a_no_sample_in_div, (r_state == acpp_pkg::ST_DIV) |-> !o_ready, "sample taken during divide")
    `ACPP_ASSERT(a_no_overwrite, o_cmd.out_load |-> !r_out_valid, "pending result overwritten")
    `ACPP_ASSERT(a_last_starts_div, (w_accept && i_sts.is_last) |=> (r_state == acpp_pkg::ST_DIV), "no divide after last sample")
    `ACPP_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

// ===== src/autocorrelation_peak_picker.sv =====
// ---------------------------------------------------------------------------
// autocorrelation_peak_picker
// Throughput: one acf sample per cycle inside a sequence of N samples, unless
// the closing sample waits for a pending result to be taken. After the last
// sample of a sequence, the restoring offset divider runs its 16 steps and then
// the result is loaded; no sample is taken until the result has been loaded.
// Reset: i_rst_n is synchronous, active low; it clears the sequence state
// and the result valid and restores the register defaults.
// ---------------------------------------------------------------------------
module autocorrelation_peak_picker #(
    parameter int MAX_LEN = acpp_pkg::DEF_MAX_LEN
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Sample input channel.
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [acpp_pkg::VALUE_W-1:0]   i_acf_value,
    // Result output channel.
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_found,
    output logic        [acpp_pkg::LAG_W-1:0]     o_peak_index,
    output logic signed [acpp_pkg::OFFSET_W-1:0]  o_peak_offset,
    output logic signed [acpp_pkg::VALUE_W-1:0]   o_peak_value,
    // APB configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic        [acpp_pkg::PADDR_W-1:0]   paddr,
    input  logic        [acpp_pkg::PDATA_W-1:0]   pwdata,
    output logic        [acpp_pkg::PDATA_W-1:0]   prdata,
    output logic                                  pready
);

    // -----------------------------------------------------------------------
    // Configuration registers. Each register is one 32-bit word: the minimum
    // lag at 0x0, the maximum lag at 0x4 and the sequence length at 0x8.
    // Writes land on the access phase; the port never inserts wait states.
    // Writes to an unmapped word are dropped and read back as zero.
    // -----------------------------------------------------------------------
    logic [acpp_pkg::LAG_W-1:0] r_min_lag;
    logic [acpp_pkg::LAG_W-1:0] r_max_lag;
    logic [acpp_pkg::LEN_W-1:0] r_seq_len;
    acpp_pkg::t_reg_idx         w_reg_idx;
    logic                       w_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = acpp_pkg::t_reg_idx'(paddr[acpp_pkg::PADDR_W-1:2]);
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_lag <= acpp_pkg::RST_MIN_LAG;
            r_max_lag <= acpp_pkg::RST_MAX_LAG;
            r_seq_len <= acpp_pkg::RST_SEQ_LEN;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                acpp_pkg::REG_MIN_LAG: r_min_lag <= pwdata[acpp_pkg::LAG_W-1:0];
                acpp_pkg::REG_MAX_LAG: r_max_lag <= pwdata[acpp_pkg::LAG_W-1:0];
                acpp_pkg::REG_SEQ_LEN: r_seq_len <= pwdata[acpp_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            acpp_pkg::REG_MIN_LAG: prdata = acpp_pkg::PDATA_W'(r_min_lag);
            acpp_pkg::REG_MAX_LAG: prdata = acpp_pkg::PDATA_W'(r_max_lag);
            acpp_pkg::REG_SEQ_LEN: prdata = acpp_pkg::PDATA_W'(r_seq_len);
            default:               prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Controller and datapath. The controller owns the handshakes: during a
    // sequence every sample transaction is taken at once and the datapath
    // updates its local maximum tracking in the same cycle. The closing
    // sample hands the best peak to the offset divider and the controller
    // waits for it before loading the result register. A result waiting in
    // that register does not stall the next sequence; only the next closing
    // sample waits until the result transaction has completed.
    // -----------------------------------------------------------------------
    acpp_pkg::t_cmd w_cmd;
    acpp_pkg::t_sts w_sts;

    acpp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    acpp_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_min_lag     (r_min_lag),
        .i_max_lag     (r_max_lag),
        .i_seq_len     (r_seq_len),
        .i_acf_value   (i_acf_value),
        .o_found       (o_found),
        .o_peak_index  (o_peak_index),
        .o_peak_offset (o_peak_offset),
        .o_peak_value  (o_peak_value)
    );

endmodule
